>>> hdl/bmon_pkg.sv
// Package with the shared types, register map and constants of the battery monitor.
`timescale 1ns / 1ps
package bmon_pkg;

  localparam int unsigned VoltW = 12;
  localparam int unsigned CurW = 10;
  localparam int unsigned LevelW = 3;
  localparam int unsigned TimeoutW = 8;
  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 32;

  localparam logic [TimeoutW-1:0] TickStep = TimeoutW'(1);
  localparam logic [CurW-1:0] ZeroCurrentCode = CurW'(775);
  localparam logic [TimeoutW-1:0] TimeoutMax = '1;

  localparam logic [LevelW-1:0] LevelEmpty = LevelW'(0);
  localparam logic [LevelW-1:0] LevelFull = LevelW'(5);

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_DISPLAY = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    REG_ESTOP = 3'd0,
    REG_CRITICAL = 3'd1,
    REG_LEVEL20 = 3'd2,
    REG_LEVEL40 = 3'd3,
    REG_LEVEL60 = 3'd4,
    REG_LEVEL80 = 3'd5,
    REG_TIMEOUT = 3'd6,
    REG_ALARM = 3'd7
  } reg_e;

  typedef struct packed {
    logic [VoltW-1:0] estop_threshold;
    logic [VoltW-1:0] critical_threshold;
    logic [VoltW-1:0] level20_threshold;
    logic [VoltW-1:0] level40_threshold;
    logic [VoltW-1:0] level60_threshold;
    logic [VoltW-1:0] level80_threshold;
    logic [TimeoutW-1:0] low_battery_timeout;
    logic [CurW-1:0] alarm_current_counts;
  } cfg_t;

  typedef struct packed {
    logic opcode;
    logic [VoltW-1:0] voltage;
    logic [CurW-1:0] current_code;
  } item_t;

  typedef struct packed {
    logic [LevelW-1:0] battery_level;
    logic emergency_stop;
    logic blink_phase;
    logic [CurW-1:0] current_magnitude;
    logic over_current;
    logic continuous_beep;
    logic short_beep;
  } result_t;

endpackage

>>> hdl/bmon_if.sv
// Valid/ready channel interfaces for the input words and the result words.
`timescale 1ns / 1ps
interface bmon_in_if;
  import bmon_pkg::*;

  logic valid;
  logic ready;
  logic opcode;
  logic [VoltW-1:0] voltage;
  logic [CurW-1:0] current_code;

  modport source (output valid, output opcode, output voltage, output current_code,
                  input ready);
  modport sink (input valid, input opcode, input voltage, input current_code,
                output ready);
endinterface

interface bmon_out_if;
  import bmon_pkg::*;

  logic valid;
  logic ready;
  logic [LevelW-1:0] battery_level;
  logic emergency_stop;
  logic blink_phase;
  logic [CurW-1:0] current_magnitude;
  logic over_current;
  logic continuous_beep;
  logic short_beep;

  modport source (output valid, output battery_level, output emergency_stop,
                  output blink_phase, output current_magnitude, output over_current,
                  output continuous_beep, output short_beep, input ready);
  modport sink (input valid, input battery_level, input emergency_stop,
                input blink_phase, input current_magnitude, input over_current,
                input continuous_beep, input short_beep, output ready);
endinterface

>>> hdl/bmon_cfg.sv
// APB register file holding the thresholds, timeout and alarm level.
`timescale 1ns / 1ps
module bmon_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bmon_pkg::ApbAddrW-1:0] paddr,
  input  logic [bmon_pkg::ApbDataW-1:0] pwdata,
  output logic [bmon_pkg::ApbDataW-1:0] prdata,
  output logic                          pready,
  output bmon_pkg::cfg_t                cfg_o
);
  import bmon_pkg::*;

  cfg_t cfg_q;
  logic wr_en;
  reg_e idx;

  assign pready = 1'b1;
  assign wr_en = psel & penable & pwrite;
  assign idx = reg_e'(paddr[ApbAddrW-1:2]);
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.estop_threshold <= '0;
      cfg_q.critical_threshold <= '0;
      cfg_q.level20_threshold <= '0;
      cfg_q.level40_threshold <= '0;
      cfg_q.level60_threshold <= '0;
      cfg_q.level80_threshold <= '0;
      cfg_q.low_battery_timeout <= TimeoutW'(255);
      cfg_q.alarm_current_counts <= CurW'(86);
    end else if (wr_en) begin
      unique case (idx)
        REG_ESTOP: cfg_q.estop_threshold <= pwdata[VoltW-1:0];
        REG_CRITICAL: cfg_q.critical_threshold <= pwdata[VoltW-1:0];
        REG_LEVEL20: cfg_q.level20_threshold <= pwdata[VoltW-1:0];
        REG_LEVEL40: cfg_q.level40_threshold <= pwdata[VoltW-1:0];
        REG_LEVEL60: cfg_q.level60_threshold <= pwdata[VoltW-1:0];
        REG_LEVEL80: cfg_q.level80_threshold <= pwdata[VoltW-1:0];
        REG_TIMEOUT: cfg_q.low_battery_timeout <= pwdata[TimeoutW-1:0];
        REG_ALARM: cfg_q.alarm_current_counts <= pwdata[CurW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_ESTOP: prdata = ApbDataW'(cfg_q.estop_threshold);
      REG_CRITICAL: prdata = ApbDataW'(cfg_q.critical_threshold);
      REG_LEVEL20: prdata = ApbDataW'(cfg_q.level20_threshold);
      REG_LEVEL40: prdata = ApbDataW'(cfg_q.level40_threshold);
      REG_LEVEL60: prdata = ApbDataW'(cfg_q.level60_threshold);
      REG_LEVEL80: prdata = ApbDataW'(cfg_q.level80_threshold);
      REG_TIMEOUT: prdata = ApbDataW'(cfg_q.low_battery_timeout);
      REG_ALARM: prdata = ApbDataW'(cfg_q.alarm_current_counts);
      default: prdata = '0;
    endcase
  end

endmodule

>>> hdl/bmon_core.sv
// Monitor state and the per-word level, timeout, current and beep logic.
`timescale 1ns / 1ps
module bmon_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  bmon_pkg::item_t   item_i,
  input  bmon_pkg::cfg_t    cfg_i,
  output bmon_pkg::result_t res_o
);
  import bmon_pkg::*;

  logic [LevelW-1:0] level_q, level_d;
  logic stop_q, stop_d;
  logic [TimeoutW-1:0] tcount_q, tcount_d;
  logic [CurW-1:0] lowest_q, lowest_d;
  logic blink_q, blink_d;
  logic [CurW-1:0] mag_q, mag_d;

  logic [TimeoutW:0] tsum;
  logic [TimeoutW-1:0] tsat;
  logic over, cbeep, sbeep;

  assign tsum = {1'b0, tcount_q} + {1'b0, TickStep};
  assign tsat = tsum[TimeoutW] ? TimeoutMax : tsum[TimeoutW-1:0];

  always_comb begin
    level_d = level_q;
    stop_d = stop_q;
    tcount_d = tcount_q;
    lowest_d = lowest_q;
    blink_d = blink_q;
    mag_d = mag_q;
    over = 1'b0;
    cbeep = 1'b0;
    sbeep = 1'b0;
    unique case (op_e'(item_i.opcode))
      OP_SAMPLE: begin
        stop_d = 1'b0;
        if (item_i.current_code < lowest_q) begin
          lowest_d = item_i.current_code;
        end
        if (item_i.voltage < cfg_i.estop_threshold) begin
          tcount_d = '0;
          stop_d = 1'b1;
        end else if (item_i.voltage < cfg_i.critical_threshold) begin
          if (tsat > cfg_i.low_battery_timeout) begin
            tcount_d = '0;
            level_d = LevelEmpty;
          end else begin
            tcount_d = tsat;
          end
        end else begin
          tcount_d = '0;
          priority if (item_i.voltage < cfg_i.level20_threshold) level_d = LevelW'(1);
          else if (item_i.voltage < cfg_i.level40_threshold) level_d = LevelW'(2);
          else if (item_i.voltage < cfg_i.level60_threshold) level_d = LevelW'(3);
          else if (item_i.voltage < cfg_i.level80_threshold) level_d = LevelW'(4);
          else level_d = LevelFull;
        end
      end
      OP_DISPLAY: begin
        blink_d = ~blink_q;
        mag_d = (lowest_q < ZeroCurrentCode) ? ZeroCurrentCode - lowest_q : '0;
        lowest_d = ZeroCurrentCode;
        over = mag_d > cfg_i.alarm_current_counts;
        cbeep = level_q == LevelEmpty;
        sbeep = stop_q & blink_d;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= LevelFull;
      stop_q <= 1'b0;
      tcount_q <= '0;
      lowest_q <= ZeroCurrentCode;
      blink_q <= 1'b0;
      mag_q <= '0;
    end else if (fire_i) begin
      level_q <= level_d;
      stop_q <= stop_d;
      tcount_q <= tcount_d;
      lowest_q <= lowest_d;
      blink_q <= blink_d;
      mag_q <= mag_d;
    end
  end

  assign res_o.battery_level = level_d;
  assign res_o.emergency_stop = stop_d;
  assign res_o.blink_phase = blink_d;
  assign res_o.current_magnitude = mag_d;
  assign res_o.over_current = over;
  assign res_o.continuous_beep = cbeep;
  assign res_o.short_beep = sbeep;

endmodule

>>> hdl/battery_level_and_current_monitor_top.sv
// Top level of the battery level and current monitor.
`timescale 1ns / 1ps
// Each input word gives exactly one result word. A word passes an input register; the monitor
// logic then updates its state and loads the result register once that register is free or
// being read, and one word can be taken every cycle as long as the output is not stalled.
// While a finished result waits in the result register, the input register can still
// take one word if it is empty. Registers sit on the APB port at byte address 4 times their
// index and may be written only while no word is in flight.
module battery_level_and_current_monitor_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bmon_in_if.sink                       in_if,
  bmon_out_if.source                    out_if,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bmon_pkg::ApbAddrW-1:0] paddr,
  input  logic [bmon_pkg::ApbDataW-1:0] pwdata,
  output logic [bmon_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);
  import bmon_pkg::*;

  cfg_t cfg;
  item_t item_q;
  logic in_valid_q;
  result_t res, res_q;
  logic out_valid_q;
  logic advance, fire;

  bmon_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign advance = ~out_valid_q | out_if.ready;
  assign fire = advance & in_valid_q;
  assign in_if.ready = ~in_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) begin
      item_q.opcode <= in_if.opcode;
      item_q.voltage <= in_if.voltage;
      item_q.current_code <= in_if.current_code;
    end
  end

  bmon_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.battery_level = res_q.battery_level;
  assign out_if.emergency_stop = res_q.emergency_stop;
  assign out_if.blink_phase = res_q.blink_phase;
  assign out_if.current_magnitude = res_q.current_magnitude;
  assign out_if.over_current = res_q.over_current;
  assign out_if.continuous_beep = res_q.continuous_beep;
  assign out_if.short_beep = res_q.short_beep;

endmodule

>>> test/tb_battery_level_and_current_monitor_top.sv
// Self-checking testbench for the battery level and current monitor top level.
`timescale 1ns / 1ps
module tb_battery_level_and_current_monitor_top;
  import bmon_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned ReportLimit = 10;
  localparam int unsigned AlarmReset = 86;
  localparam int unsigned VoltMax = (1 << VoltW) - 1;
  localparam int unsigned CurMax = (1 << CurW) - 1;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic pready;

  bmon_in_if in_if ();
  bmon_out_if out_if ();

  battery_level_and_current_monitor_top u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Register mirror and monitor state as the predictor sees them.
  logic [VoltW-1:0] band_limit [6];
  logic [TimeoutW-1:0] timeout_limit;
  logic [CurW-1:0] alarm_limit;
  logic [LevelW-1:0] level_st;
  logic stop_st;
  logic [TimeoutW-1:0] low_count;
  logic [CurW-1:0] min_current;
  logic blink_st;
  logic [CurW-1:0] magnitude_st;

  item_t tick_queue[$];
  result_t expected_readings[$];
  int unsigned ticks_in_flight = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  logic [15:0] stall_pattern = '1;
  int unsigned stall_age = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic result_t predict_readout(item_t t);
    result_t r;
    logic [TimeoutW:0] sum;
    r = '0;
    if (op_e'(t.opcode) == OP_SAMPLE) begin
      stop_st = 1'b0;
      if (t.current_code < min_current) begin
        min_current = t.current_code;
      end
      if (t.voltage < band_limit[REG_ESTOP]) begin
        low_count = '0;
        stop_st = 1'b1;
      end else if (t.voltage < band_limit[REG_CRITICAL]) begin
        sum = {1'b0, low_count} + {1'b0, TickStep};
        low_count = (sum > {1'b0, TimeoutMax}) ? TimeoutMax : sum[TimeoutW-1:0];
        if (low_count > timeout_limit) begin
          low_count = '0;
          level_st = LevelEmpty;
        end
      end else begin
        low_count = '0;
        if (t.voltage < band_limit[REG_LEVEL20]) begin
          level_st = LevelW'(1);
        end else if (t.voltage < band_limit[REG_LEVEL40]) begin
          level_st = LevelW'(2);
        end else if (t.voltage < band_limit[REG_LEVEL60]) begin
          level_st = LevelW'(3);
        end else if (t.voltage < band_limit[REG_LEVEL80]) begin
          level_st = LevelW'(4);
        end else begin
          level_st = LevelFull;
        end
      end
    end else begin
      blink_st = ~blink_st;
      magnitude_st = (min_current < ZeroCurrentCode) ? ZeroCurrentCode - min_current : '0;
      min_current = ZeroCurrentCode;
      r.over_current = magnitude_st > alarm_limit;
      r.continuous_beep = level_st == LevelEmpty;
      r.short_beep = stop_st & blink_st;
    end
    r.battery_level = level_st;
    r.emergency_stop = stop_st;
    r.blink_phase = blink_st;
    r.current_magnitude = magnitude_st;
    return r;
  endfunction

  task automatic wait_drained();
    while (ticks_in_flight != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, int unsigned value);
    int unsigned w;
    logic [ApbDataW-1:0] field;
    case (idx)
      REG_TIMEOUT: w = TimeoutW;
      REG_ALARM: w = CurW;
      default: w = VoltW;
    endcase
    field = value & ((32'd1 << w) - 1);
    case (idx)
      REG_TIMEOUT: timeout_limit = field[TimeoutW-1:0];
      REG_ALARM: alarm_limit = field[CurW-1:0];
      default: band_limit[idx] = field[VoltW-1:0];
    endcase
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ApbAddrW'({idx, 2'b00});
    pwdata <= field | ($urandom() << w);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(int unsigned estop, int unsigned crit, int unsigned l20,
                            int unsigned l40, int unsigned l60, int unsigned l80,
                            int unsigned tmo, int unsigned alarm);
    wait_drained();
    write_reg(REG_ESTOP, estop);
    write_reg(REG_CRITICAL, crit);
    write_reg(REG_LEVEL20, l20);
    write_reg(REG_LEVEL40, l40);
    write_reg(REG_LEVEL60, l60);
    write_reg(REG_LEVEL80, l80);
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_ALARM, alarm);
  endtask

  task automatic random_config();
    int unsigned t[6];
    int unsigned acc;
    acc = 0;
    if ($urandom_range(0, 3) == 0) begin
      foreach (t[i]) t[i] = $urandom_range(VoltMax, 0);
    end else begin
      foreach (t[i]) begin
        acc += $urandom_range(700, 0);
        if (acc > VoltMax) acc = VoltMax;
        t[i] = acc;
      end
    end
    set_config(t[0], t[1], t[2], t[3], t[4], t[5],
               ($urandom_range(0, 3) == 0) ? $urandom_range(255, 0) : $urandom_range(12, 0),
               ($urandom_range(0, 1) == 0) ? $urandom_range(CurMax, 0) : $urandom_range(200, 0));
  endtask

  task automatic push_tick(op_e op, int unsigned v, int unsigned c);
    item_t t;
    t.opcode = op;
    t.voltage = VoltW'(v);
    t.current_code = CurW'(c);
    tick_queue.push_back(t);
    ticks_in_flight++;
  endtask

  // Picks a voltage inside band b: stop, critical, then the five charge levels.
  function automatic int unsigned band_voltage(int b);
    int unsigned lo;
    int unsigned hi;
    lo = (b == 0) ? 0 : band_limit[b-1];
    hi = (b == 6) ? VoltMax + 1 : band_limit[b];
    if (lo < hi) return $urandom_range(hi - 1, lo);
    return $urandom_range(VoltMax, 0);
  endfunction

  function automatic int unsigned random_current();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return CurMax;
      2: return int'(ZeroCurrentCode) + $urandom_range(2, 0) - 1;
      default: return $urandom_range(CurMax, 0);
    endcase
  endfunction

  task automatic add_random_ticks(int n);
    int k;
    int mode;
    int lim;
    int len;
    int v;
    k = 0;
    while (k < n) begin
      if ($urandom_range(0, 4) == 0) begin
        push_tick(OP_DISPLAY, $urandom_range(VoltMax, 0), $urandom_range(CurMax, 0));
        k++;
      end else begin
        mode = $urandom_range(9, 0);
        if (mode >= 6 && mode <= 7 && band_limit[REG_ESTOP] < band_limit[REG_CRITICAL]) begin
          // A run of critical samples so that the low battery timeout can expire.
          lim = (timeout_limit + 3 > 30) ? 30 : timeout_limit + 3;
          len = $urandom_range(lim, 1);
          repeat (len) begin
            if ($urandom_range(0, 5) == 0) begin
              push_tick(OP_DISPLAY, $urandom_range(VoltMax, 0), $urandom_range(CurMax, 0));
            end
            push_tick(OP_SAMPLE, band_voltage(1), random_current());
          end
          k += len;
        end else begin
          if (mode <= 3) begin
            v = band_voltage($urandom_range(6, 0));
          end else if (mode <= 5) begin
            v = int'(band_limit[$urandom_range(5, 0)]) + int'($urandom_range(2, 0)) - 1;
            if (v < 0) v = 0;
            if (v > int'(VoltMax)) v = VoltMax;
          end else begin
            v = $urandom_range(VoltMax, 0);
          end
          push_tick(OP_SAMPLE, v, random_current());
          k++;
        end
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.opcode = OP_SAMPLE;
    in_if.voltage = '0;
    in_if.current_code = '0;
    out_if.ready = 1'b1;
    foreach (band_limit[i]) band_limit[i] = '0;
    timeout_limit = TimeoutMax;
    alarm_limit = CurW'(AlarmReset);
    level_st = LevelFull;
    stop_st = 1'b0;
    low_count = '0;
    min_current = ZeroCurrentCode;
    blink_st = 1'b0;
    magnitude_st = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_tick(OP_SAMPLE, VoltMax, CurMax);
    push_tick(OP_DISPLAY, 0, 0);

    set_config(100, 300, 500, 1000, 2000, 3000, 2, AlarmReset);
    push_tick(OP_SAMPLE, VoltMax, CurMax);
    push_tick(OP_SAMPLE, 2999, ZeroCurrentCode);
    push_tick(OP_SAMPLE, 1999, ZeroCurrentCode - 1);
    push_tick(OP_SAMPLE, 999, 0);
    push_tick(OP_SAMPLE, 499, 500);
    push_tick(OP_DISPLAY, VoltMax, CurMax);
    repeat (3) push_tick(OP_SAMPLE, 150, ZeroCurrentCode + 1);
    push_tick(OP_DISPLAY, 0, 0);
    push_tick(OP_SAMPLE, 0, ZeroCurrentCode + 1);
    push_tick(OP_DISPLAY, 0, 0);
    push_tick(OP_SAMPLE, 100, CurMax);
    push_tick(OP_SAMPLE, 300, CurMax);
    push_tick(OP_DISPLAY, 0, 0);
    push_tick(OP_SAMPLE, VoltMax, ZeroCurrentCode - 1);
    push_tick(OP_DISPLAY, 0, 0);

    // Every sample below full scale is critical and expires at once.
    set_config(0, VoltMax, VoltMax, VoltMax, VoltMax, VoltMax, 0, 0);
    add_random_ticks(60);

    // Every sample below full scale is an emergency stop.
    set_config(VoltMax, VoltMax, VoltMax, VoltMax, VoltMax, VoltMax, 255, CurMax);
    add_random_ticks(60);

    // A long critical stretch drives the timeout counter into saturation.
    set_config(0, 2048, 2500, 3000, 3500, 4000, 255, 300);
    for (int i = 0; i < 300; i++) begin
      if (i % 25 == 24) push_tick(OP_DISPLAY, 0, 0);
      push_tick(OP_SAMPLE, band_voltage(1), random_current());
    end
    wait_drained();
    write_reg(REG_TIMEOUT, 254);
    repeat (3) push_tick(OP_SAMPLE, band_voltage(1), random_current());
    push_tick(OP_DISPLAY, 0, 0);
    add_random_ticks(60);

    repeat (6) begin
      random_config();
      add_random_ticks(100);
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Sender: bursts of words separated by random gaps.
  always @(posedge clk_i) begin : drive_ticks
    item_t word;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        word.opcode = in_if.opcode;
        word.voltage = in_if.voltage;
        word.current_code = in_if.current_code;
        expected_readings.push_back(predict_readout(word));
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (tick_queue.size() != 0) begin
          word = tick_queue.pop_front();
          in_if.opcode <= word.opcode;
          in_if.voltage <= word.voltage;
          in_if.current_code <= word.current_code;
          in_if.valid <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(24, 1);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(6, 1);
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result word and stalls on a rotating pattern.
  always @(posedge clk_i) begin : check_readings
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got.battery_level = out_if.battery_level;
        got.emergency_stop = out_if.emergency_stop;
        got.blink_phase = out_if.blink_phase;
        got.current_magnitude = out_if.current_magnitude;
        got.over_current = out_if.over_current;
        got.continuous_beep = out_if.continuous_beep;
        got.short_beep = out_if.short_beep;
        if (expected_readings.size() == 0) begin
          if (mismatches < ReportLimit) $display("unexpected result word at %0t", $realtime);
          mismatches++;
        end else begin
          want = expected_readings.pop_front();
          ticks_in_flight--;
          if (got !== want) begin
            if (mismatches < ReportLimit) begin
              $display("at %0t exp level %0d stop %b blink %b mag %0d over %b cb %b sb %b",
                       $realtime, want.battery_level, want.emergency_stop, want.blink_phase,
                       want.current_magnitude, want.over_current, want.continuous_beep,
                       want.short_beep);
              $display("       got level %0d stop %b blink %b mag %0d over %b cb %b sb %b",
                       got.battery_level, got.emergency_stop, got.blink_phase,
                       got.current_magnitude, got.over_current, got.continuous_beep,
                       got.short_beep);
            end
            mismatches++;
          end
        end
      end
      stall_age++;
      if (stall_age == 64) begin
        stall_age = 0;
        stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom());
        if (stall_pattern == '0) stall_pattern = 16'h0001;
      end
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      out_if.ready <= stall_pattern[0];
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

endmodule

>>> filelist.f
hdl/bmon_pkg.sv
hdl/bmon_if.sv
hdl/bmon_cfg.sv
hdl/bmon_core.sv
hdl/battery_level_and_current_monitor_top.sv
test/tb_battery_level_and_current_monitor_top.sv
